// ===== src/ptf_pkg.sv =====
// shared types and constants for the page table translate and fill unit
// no dependencies; used by ptf_free_find and page_table_translate_fill_unit
package ptf_pkg;

    // default sizes
    localparam int PAGE_BYTES_DEF = 128;
    localparam int MAX_VPAGES_DEF = 64;
    localparam int NUM_FRAMES_DEF = 128;

    // fixed field widths
    localparam int VADDR_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int PHYS_W      = 14;
    localparam int FRAME_OUT_W = 7;
    localparam int PCOUNT_W    = 7;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic [PCOUNT_W-1:0] PAGE_COUNT_RESET = 7'd64;

    // free frame search groups
    localparam int FIND_GROUP = 8;

    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_FILL      = 2'd1,
        OP_RELEASE   = 2'd2,
        OP_IGNORE    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_ADDR   = 3'd1,
        ST_FAULT  = 3'd2,
        ST_RO     = 3'd3,
        ST_LOADED = 3'd4,
        ST_NOMEM  = 3'd5
    } status_t;

endpackage

// ===== src/ptf_free_find.sv =====
// lowest free frame search over the frame busy bitmap
// depends on ptf_pkg (group size)
module ptf_free_find #(
    parameter int NUM_FRAMES = ptf_pkg::NUM_FRAMES_DEF
) (
    input  logic [NUM_FRAMES-1:0]         busy,
    output logic                          found,
    output logic [$clog2(NUM_FRAMES)-1:0] frame_idx
);

    localparam int FR_W  = $clog2(NUM_FRAMES);
    localparam int GSZ   = ptf_pkg::FIND_GROUP;
    localparam int NG    = (NUM_FRAMES + GSZ - 1) / GSZ;
    localparam int PAD_N = NG * GSZ;
    localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
    localparam int BW    = $clog2(GSZ);

    logic [PAD_N-1:0] busy_pad;
    logic [NG-1:0]    group_free;
    logic [GW-1:0]    grp_sel;
    logic [GSZ-1:0]   grp_bits;
    logic [BW-1:0]    bit_sel;
    logic [GW+BW-1:0] idx_wide;

    // unused tail frames read as busy
    assign busy_pad = {{(PAD_N - NUM_FRAMES){1'b1}}, busy};

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            group_free[g] = ~&busy_pad[g*GSZ +: GSZ];
        end
    end

    // first level: lowest group with a free frame
    always_comb begin
        grp_sel = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (group_free[g]) begin
                grp_sel = GW'(g);
            end
        end
    end

    assign grp_bits = busy_pad[grp_sel*GSZ +: GSZ];

    // second level: lowest free bit in that group
    always_comb begin
        bit_sel = '0;
        for (int b = GSZ - 1; b >= 0; b--) begin
            if (!grp_bits[b]) begin
                bit_sel = BW'(b);
            end
        end
    end

    assign idx_wide  = {grp_sel, bit_sel};
    assign found     = |group_free;
    assign frame_idx = idx_wide[FR_W-1:0];

endmodule

// ===== src/page_table_translate_fill_unit.sv =====
// top level: linear page table with translate, demand fill and release
// depends on ptf_pkg and ptf_free_find
//
// usage
//   s_ channel takes one request per cycle while s_tready is high: s_tuser carries the operation
//   (translate, fault fill, release; code three is dropped without a result),
//   s_tdata carries the virtual address and the write and read-only flags.
//   m_ channel returns one result per request not dropped: status, physical address and
//   frame number, in request order.
//   page_count_we / page_count_wdata set the number of live virtual pages;
//   write it only while no request is in flight.
// flow
//   a request accepted into the input register is worked on against the page
//   table and leaves through the output register, where m_tvalid rises. one
//   request per cycle is sustained while m_tready stays high; the frame store
//   read is registered at acceptance and a fill in flight is forwarded into it.
// reset
//   all pages invalid, all frames free, page count 64, both channels empty.
// stalls
//   when m_tready is low the result waits in the output register and the
//   request behind it waits in the input register; s_tready then drops.
module page_table_translate_fill_unit #(
    parameter int PAGE_BYTES = ptf_pkg::PAGE_BYTES_DEF,
    parameter int MAX_VPAGES = ptf_pkg::MAX_VPAGES_DEF,
    parameter int NUM_FRAMES = ptf_pkg::NUM_FRAMES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             page_count_we,
    input  logic [ptf_pkg::PCOUNT_W-1:0]     page_count_wdata,
    // request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ptf_pkg::IN_TDATA_W-1:0]   s_tdata,  // vaddr[31:0], is_write[32], read_only[33], zero pad
    input  logic [1:0]                       s_tuser,  // op[1:0]
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ptf_pkg::OUT_TDATA_W-1:0]  m_tdata   // status[2:0], phys_addr[16:3], frame[23:17]
);

    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int VPN_W  = ptf_pkg::VADDR_W - OFF_W;
    localparam int IDX_W  = (MAX_VPAGES > 1) ? $clog2(MAX_VPAGES) : 1;
    localparam int FR_W   = $clog2(NUM_FRAMES);
    localparam int PHYS_W = ptf_pkg::PHYS_W;
    localparam int FOUT_W = ptf_pkg::FRAME_OUT_W;

    // ---------------- input register ----------------
    logic                        in_valid_reg;
    ptf_pkg::op_t                in_op_reg;
    logic [ptf_pkg::VADDR_W-1:0] in_vaddr_reg;
    logic                        in_wr_reg;
    logic                        in_ro_reg;
    logic [FR_W-1:0]             frame_rd_reg;   // page's frame, read at acceptance

    // ---------------- page table and frame bitmap ----------------
    logic [MAX_VPAGES-1:0]       entry_valid_reg;
    logic [MAX_VPAGES-1:0]       entry_used_reg;
    logic [MAX_VPAGES-1:0]       entry_dirty_reg;
    logic [MAX_VPAGES-1:0]       entry_prot_reg;
    logic [NUM_FRAMES-1:0]       frame_busy_reg;
    logic [FR_W-1:0]             frame_mem [MAX_VPAGES];
    logic [ptf_pkg::PCOUNT_W-1:0] page_count_reg;

    // ---------------- output register ----------------
    logic                        m_valid_reg;
    ptf_pkg::status_t            m_status_reg;
    logic [PHYS_W-1:0]           m_phys_reg;
    logic [FOUT_W-1:0]           m_frame_reg;

    // ---------------- working logic ----------------
    logic                        s_fire;
    logic                        advance;
    logic                        emit;
    logic [IDX_W-1:0]            s_idx;
    logic [VPN_W-1:0]            vpn;
    logic [OFF_W-1:0]            off;
    logic [IDX_W-1:0]            idx;
    logic [VPN_W-1:0]            limit;
    logic                        in_range;
    logic                        pg_valid;
    logic                        pg_prot;
    logic                        free_found;
    logic [FR_W-1:0]             free_idx;
    logic [FR_W+OFF_W+PHYS_W-1:0] pa_wide;
    logic [FR_W+FOUT_W-1:0]      page_fr_wide;
    logic [FR_W+FOUT_W-1:0]      free_fr_wide;

    ptf_pkg::status_t            res_status;
    logic [PHYS_W-1:0]           res_phys;
    logic [FOUT_W-1:0]           res_frame;
    logic                        do_touch;     // translate hit: set used, maybe dirty
    logic                        do_fill;      // install free frame
    logic                        do_release;   // free page's frame

    assign s_fire  = s_tvalid && s_tready;
    assign advance = in_valid_reg && ((in_op_reg == ptf_pkg::OP_IGNORE) || !m_valid_reg
                     || m_tready);
    assign emit    = advance && (in_op_reg != ptf_pkg::OP_IGNORE);
    assign s_tready = !in_valid_reg || advance;

    assign s_idx = s_tdata[OFF_W +: IDX_W];
    assign vpn   = in_vaddr_reg[ptf_pkg::VADDR_W-1:OFF_W];
    assign off   = in_vaddr_reg[OFF_W-1:0];
    assign idx   = vpn[IDX_W-1:0];

    // active page count is the smaller of the register and the table size
    assign limit = (VPN_W'(page_count_reg) < VPN_W'(MAX_VPAGES)) ? VPN_W'(page_count_reg)
                                                                 : VPN_W'(MAX_VPAGES);
    assign in_range = vpn < limit;
    assign pg_valid = in_range && entry_valid_reg[idx];
    assign pg_prot  = entry_prot_reg[idx];

    ptf_free_find #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_free_find (
        .busy      (frame_busy_reg),
        .found     (free_found),
        .frame_idx (free_idx)
    );

    // frame * PAGE_BYTES + offset, cut to the result field width
    assign pa_wide      = {{PHYS_W{1'b0}}, frame_rd_reg, off};
    assign page_fr_wide = {{FOUT_W{1'b0}}, frame_rd_reg};
    assign free_fr_wide = {{FOUT_W{1'b0}}, free_idx};

    always_comb begin
        res_status = ptf_pkg::ST_ADDR;
        res_phys   = '0;
        res_frame  = '0;
        do_touch   = 1'b0;
        do_fill    = 1'b0;
        do_release = 1'b0;
        if (in_range) begin
            case (in_op_reg)
                ptf_pkg::OP_TRANSLATE: begin
                    if (!pg_valid) begin
                        res_status = ptf_pkg::ST_FAULT;
                    end else if (in_wr_reg && pg_prot) begin
                        res_status = ptf_pkg::ST_RO;
                        res_frame  = page_fr_wide[FOUT_W-1:0];
                    end else begin
                        res_status = ptf_pkg::ST_OK;
                        res_phys   = pa_wide[PHYS_W-1:0];
                        res_frame  = page_fr_wide[FOUT_W-1:0];
                        do_touch   = 1'b1;
                    end
                end
                ptf_pkg::OP_FILL: begin
                    if (pg_valid) begin
                        res_status = ptf_pkg::ST_LOADED;
                        res_frame  = page_fr_wide[FOUT_W-1:0];
                    end else if (!free_found) begin
                        res_status = ptf_pkg::ST_NOMEM;
                    end else begin
                        res_status = ptf_pkg::ST_OK;
                        res_frame  = free_fr_wide[FOUT_W-1:0];
                        do_fill    = 1'b1;
                    end
                end
                ptf_pkg::OP_RELEASE: begin
                    if (!pg_valid) begin
                        res_status = ptf_pkg::ST_FAULT;
                    end else begin
                        res_status = ptf_pkg::ST_OK;
                        res_frame  = page_fr_wide[FOUT_W-1:0];
                        do_release = 1'b1;
                    end
                end
                default: begin
                    res_status = ptf_pkg::ST_ADDR;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_fire) begin
            in_op_reg    <= ptf_pkg::op_t'(s_tuser);
            in_vaddr_reg <= s_tdata[ptf_pkg::VADDR_W-1:0];
            in_wr_reg    <= s_tdata[32];
            in_ro_reg    <= s_tdata[33];
        end
    end

    // frame store: one write port for fills, one registered read at acceptance
    // a fill leaving at the same edge is forwarded to the read
    always_ff @(posedge aclk) begin
        if (advance && do_fill) begin
            frame_mem[idx] <= free_idx;
        end
        if (s_fire) begin
            if (advance && do_fill && (idx == s_idx)) begin
                frame_rd_reg <= free_idx;
            end else begin
                frame_rd_reg <= frame_mem[s_idx];
            end
        end
    end

    // page flags and frame bitmap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            entry_used_reg  <= '0;
            entry_dirty_reg <= '0;
            entry_prot_reg  <= '0;
            frame_busy_reg  <= '0;
        end else if (advance) begin
            if (do_touch) begin
                entry_used_reg[idx] <= 1'b1;
                if (in_wr_reg) begin
                    entry_dirty_reg[idx] <= 1'b1;
                end
            end
            if (do_fill) begin
                entry_valid_reg[idx]     <= 1'b1;
                entry_used_reg[idx]      <= 1'b0;
                entry_dirty_reg[idx]     <= 1'b0;
                entry_prot_reg[idx]      <= in_ro_reg;
                frame_busy_reg[free_idx] <= 1'b1;
            end
            if (do_release) begin
                entry_valid_reg[idx]         <= 1'b0;
                frame_busy_reg[frame_rd_reg] <= 1'b0;
            end
        end
    end

    // page count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_count_reg <= ptf_pkg::PAGE_COUNT_RESET;
        end else if (page_count_we) begin
            page_count_reg <= page_count_wdata;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit) begin
            m_status_reg <= res_status;
            m_phys_reg   <= res_phys;
            m_frame_reg  <= res_frame;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_frame_reg, m_phys_reg, m_status_reg};

    // ---------------- checks ----------------
    // the number of busy frames equals the number of valid pages
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(frame_busy_reg) == $countones(entry_valid_reg))
        else $error("busy frame count differs from valid page count");

    // a dirty page has always been used since its fill
    assert property (@(posedge aclk) disable iff (!aresetn)
        (entry_dirty_reg & ~entry_used_reg) == '0)
        else $error("dirty page without used flag");

    // the search never hands out a busy frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        free_found |-> !frame_busy_reg[free_idx])
        else $error("free frame search picked a busy frame");

    // a successful fill leaves its page valid and its frame busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && do_fill) |=> (entry_valid_reg[$past(idx)]
                                  && frame_busy_reg[$past(free_idx)]))
        else $error("fill did not install page");

endmodule
